[rtl/q_table_update_engine_unit_macros.svh]
// Assertion macros for the Q table update engine
`ifndef Q_TABLE_UPDATE_ENGINE_UNIT_MACROS_SVH
`define Q_TABLE_UPDATE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define QTUE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define QTUE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qtue_pkg.sv]
// Shared constants, types and helpers of the Q table update engine
`timescale 1ns / 1ps
`default_nettype none

package qtue_pkg;

    localparam int NUM_STATES  = 8;
    localparam int NUM_ACTIONS = 4;
    localparam int Q_WIDTH     = 16;

    // fixed field widths
    localparam int STATE_W  = 3;
    localparam int ACTION_W = 2;
    localparam int REWARD_W = 8;
    localparam int RATE_W   = 9;
    localparam int CFG_IDX_W = 1;

    localparam int ROW_W  = $clog2(NUM_STATES);
    localparam int COL_W  = $clog2(NUM_ACTIONS);
    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);

    localparam logic [RATE_W-1:0] RATE_ONE        = 9'd256;
    localparam logic [RATE_W-1:0] LEARN_RATE_RST  = 9'd26;
    localparam logic [RATE_W-1:0] DISCOUNT_RST    = 9'd230;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT      = 1'b1;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    // arithmetic scaling
    localparam int REWARD_SHIFT = 16;
    localparam int OLD_SHIFT    = 8;
    localparam int ACC_SHIFT    = 16;
    localparam int ROUND_HALF   = 32768;

    localparam int P1_W  = Q_WIDTH + 10;
    localparam int P2_W  = Q_WIDTH + 10;
    localparam int T_W   = ((P1_W > REWARD_W + REWARD_SHIFT) ? P1_W : REWARD_W + REWARD_SHIFT) + 1;
    localparam int P3_W  = T_W + 10;
    localparam int ACC_W = ((P2_W + OLD_SHIFT > P3_W) ? P2_W + OLD_SHIFT : P3_W) + 2;
    localparam int SH_W  = ACC_W - ACC_SHIFT;

    localparam logic signed [Q_WIDTH-1:0] Q_MAX_V = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam logic signed [Q_WIDTH-1:0] Q_MIN_V = {1'b1, {(Q_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [RATE_W-1:0]          alpha;
        logic [RATE_W-1:0]          gamma;
        logic signed [REWARD_W-1:0] reward;
        logic signed [Q_WIDTH-1:0]  old_q;
        logic signed [Q_WIDTH-1:0]  max_q;
    } calc_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [Q_WIDTH-1:0] value;
    } calc_rsp_t;

    function automatic logic [ROW_W-1:0] row_wrap(input logic [STATE_W-1:0] v);
        logic [STATE_W:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 4; i++) begin
            if (int'(r) >= NUM_STATES)
                r = (STATE_W+1)'(int'(r) - NUM_STATES);
        end
        return ROW_W'(r);
    endfunction

    function automatic logic [COL_W-1:0] col_wrap(input logic [ACTION_W-1:0] v);
        logic [ACTION_W:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 2; i++) begin
            if (int'(r) >= NUM_ACTIONS)
                r = (ACTION_W+1)'(int'(r) - NUM_ACTIONS);
        end
        return COL_W'(r);
    endfunction

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(NUM_ACTIONS)) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

[rtl/q_table_update_engine_unit.sv]
// Q table update engine top level: sequencer, row scan, blend pipeline and table store
//
// Input channel: in_valid / in_stall carries one word per item (func, cur_state,
// next_state_idx, action, reward). Output channel: out_valid / out_stall carries
// best_action, best_q and new_q. Registers are written through cfg_wr_en,
// cfg_idx and cfg_data; the user must write them only while the block is
// idle, as the block itself does not enforce it. One item is processed at a
// time. The table store has a single read port, so a row scan reads one
// action's entry per cycle and an update adds one more read for the old entry;
// the blend then runs through a four-stage multiply pipeline. A query passes
// the scan, drain and done steps; an update also passes the start and calc
// steps. A finished result is held in the output register, so the next word
// is accepted while it waits; a stalled receiver holds the block in its final
// step only once the following result is ready.
// Reset clears the table (per-entry valid flags, unwritten entries read as
// zero), loads learning_rate 26 and discount 230, and empties the output.
`timescale 1ns / 1ps
`default_nettype none

`include "q_table_update_engine_unit_macros.svh"

module q_table_update_engine_unit
    import qtue_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]       cfg_idx,
    input  wire logic [RATE_W-1:0]          cfg_data,

    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       func,
    input  wire logic [STATE_W-1:0]         cur_state,
    input  wire logic [STATE_W-1:0]         next_state_idx,
    input  wire logic [ACTION_W-1:0]        action,
    input  wire logic signed [REWARD_W-1:0] reward,

    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [COL_W-1:0]                best_action,
    output logic signed [Q_WIDTH-1:0]       best_q,
    output logic signed [Q_WIDTH-1:0]       new_q
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_START,
        S_CALC,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0]          lr_reg, lr_next;
    logic [RATE_W-1:0]          disc_reg, disc_next;
    logic                       func_reg, func_next;
    logic [ROW_W-1:0]           cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]           nxt_row_reg, nxt_row_next;
    logic [COL_W-1:0]           act_col_reg, act_col_next;
    logic signed [REWARD_W-1:0] reward_reg, reward_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [CNT_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       rd_ent_vld_reg, rd_ent_vld_next;
    logic [DEPTH-1:0]           ent_vld_reg, ent_vld_next;
    logic [COL_W-1:0]           best_col_reg, best_col_next;
    logic signed [Q_WIDTH-1:0]  best_val_reg, best_val_next;
    logic signed [Q_WIDTH-1:0]  old_reg, old_next;
    logic signed [Q_WIDTH-1:0]  new_reg, new_next;
    logic                       out_valid_reg, out_valid_next;
    logic [COL_W-1:0]           out_col_reg, out_col_next;
    logic signed [Q_WIDTH-1:0]  out_best_reg, out_best_next;
    logic signed [Q_WIDTH-1:0]  out_new_reg, out_new_next;

    logic                      calc_start;
    calc_req_t                 calc_req;
    calc_rsp_t                 calc_rsp;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [Q_WIDTH-1:0]        mem_rdata;
    logic [CNT_W-1:0]          last_cnt;
    logic [ROW_W-1:0]          scan_row;
    logic signed [Q_WIDTH-1:0] rd_entry;

    qtue_ram #(
        .WIDTH (Q_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (calc_rsp.value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qtue_calc u_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (calc_start),
        .req   (calc_req),
        .rsp   (calc_rsp)
    );

    always_comb
    begin
        calc_req.alpha  = (lr_reg > RATE_ONE) ? RATE_ONE : lr_reg;
        calc_req.gamma  = (disc_reg > RATE_ONE) ? RATE_ONE : disc_reg;
        calc_req.reward = reward_reg;
        calc_req.old_q  = old_reg;
        calc_req.max_q  = best_val_reg;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign best_action = out_col_reg;
    assign best_q      = out_best_reg;
    assign new_q       = out_new_reg;

    always_comb
    begin
        state_next      = state_reg;
        lr_next         = lr_reg;
        disc_next       = disc_reg;
        func_next       = func_reg;
        cur_row_next    = cur_row_reg;
        nxt_row_next    = nxt_row_reg;
        act_col_next    = act_col_reg;
        reward_next     = reward_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        ent_vld_next    = ent_vld_reg;
        best_col_next   = best_col_reg;
        best_val_next   = best_val_reg;
        old_next        = old_reg;
        new_next        = new_reg;
        out_valid_next  = out_valid_reg;
        out_col_next    = out_col_reg;
        out_best_next   = out_best_reg;
        out_new_next    = out_new_reg;
        calc_start      = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = entry_addr(cur_row_reg, act_col_reg);
        mem_raddr       = '0;

        last_cnt = (func_reg == FUNC_QUERY) ? CNT_W'(NUM_ACTIONS - 1) : CNT_W'(NUM_ACTIONS);
        scan_row = (func_reg == FUNC_QUERY) ? cur_row_reg : nxt_row_reg;
        rd_entry = rd_ent_vld_reg ? $signed(mem_rdata) : '0;

        if (cfg_wr_en) begin
            case (cfg_idx)
                CFG_LEARNING_RATE: lr_next   = cfg_data;
                CFG_DISCOUNT:      disc_next = cfg_data;
                default:           ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        // returning read data: scan columns first, then the old entry
        if (rd_vld_reg) begin
            if (rd_idx_reg < CNT_W'(NUM_ACTIONS)) begin
                if (rd_idx_reg == '0 || rd_entry >= best_val_reg) begin
                    best_val_next = rd_entry;
                    best_col_next = COL_W'(rd_idx_reg);
                end
            end else begin
                old_next = rd_entry;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    func_next    = func;
                    cur_row_next = row_wrap(cur_state);
                    nxt_row_next = row_wrap(next_state_idx);
                    act_col_next = col_wrap(action);
                    reward_next  = reward;
                    cnt_next     = '0;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                if (cnt_reg < CNT_W'(NUM_ACTIONS))
                    mem_raddr = entry_addr(scan_row, COL_W'(cnt_reg));
                else
                    mem_raddr = entry_addr(cur_row_reg, act_col_reg);
                rd_vld_next = 1'b1;
                rd_idx_next = cnt_reg;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == last_cnt)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                new_next   = '0;
                state_next = (func_reg == FUNC_QUERY) ? S_DONE : S_START;
            end
            S_START:
            begin
                calc_start = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (calc_rsp.done) begin
                    mem_we                  = 1'b1;
                    ent_vld_next[mem_waddr] = 1'b1;
                    new_next                = calc_rsp.value;
                    state_next              = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall) begin
                    out_valid_next = 1'b1;
                    out_col_next   = best_col_reg;
                    out_best_next  = best_val_reg;
                    out_new_next   = new_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the valid flag travels with the read data
        rd_ent_vld_next = ent_vld_reg[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            lr_reg         <= LEARN_RATE_RST;
            disc_reg       <= DISCOUNT_RST;
            func_reg       <= FUNC_UPDATE;
            cur_row_reg    <= '0;
            nxt_row_reg    <= '0;
            act_col_reg    <= '0;
            reward_reg     <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            rd_ent_vld_reg <= 1'b0;
            ent_vld_reg    <= '0;
            best_col_reg   <= '0;
            best_val_reg   <= '0;
            old_reg        <= '0;
            new_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_col_reg    <= '0;
            out_best_reg   <= '0;
            out_new_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            lr_reg         <= lr_next;
            disc_reg       <= disc_next;
            func_reg       <= func_next;
            cur_row_reg    <= cur_row_next;
            nxt_row_reg    <= nxt_row_next;
            act_col_reg    <= act_col_next;
            reward_reg     <= reward_next;
            cnt_reg        <= cnt_next;
            rd_vld_reg     <= rd_vld_next;
            rd_idx_reg     <= rd_idx_next;
            rd_ent_vld_reg <= rd_ent_vld_next;
            ent_vld_reg    <= ent_vld_next;
            best_col_reg   <= best_col_next;
            best_val_reg   <= best_val_next;
            old_reg        <= old_next;
            new_reg        <= new_next;
            out_valid_reg  <= out_valid_next;
            out_col_reg    <= out_col_next;
            out_best_reg   <= out_best_next;
            out_new_reg    <= out_new_next;
        end
    end

    `QTUE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not start work")
    `QTUE_ASSERT_IMP(a_calc_done_in_calc, calc_rsp.done, state_reg == S_CALC, "blend result outside calc step")
    `QTUE_ASSERT_IMP(a_read_data_in_scan, rd_vld_reg, state_reg == S_READ || state_reg == S_DRAIN, "read data returned outside scan")

endmodule

`default_nettype wire

[rtl/qtue_ram.sv]
// Generic single-port-write RAM with one registered read port
`timescale 1ns / 1ps
`default_nettype none

module qtue_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/qtue_calc.sv]
// Four-stage pipeline for the Q value blend, rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module qtue_calc
    import qtue_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire calc_req_t req,
    output calc_rsp_t      rsp
);

    logic [3:0] vld_reg;
    logic [3:0] vld_next;

    logic signed [P1_W-1:0]     p1_reg;
    logic signed [P2_W-1:0]     p2_reg;
    logic signed [P2_W-1:0]     p2b_reg;
    logic signed [P2_W-1:0]     p2c_reg;
    logic [RATE_W-1:0]          alpha1_reg;
    logic [RATE_W-1:0]          alpha2_reg;
    logic signed [REWARD_W-1:0] rwd1_reg;
    logic signed [T_W-1:0]      t_reg;
    logic signed [P3_W-1:0]     p3_reg;
    logic signed [Q_WIDTH-1:0]  value_reg;

    logic signed [P1_W-1:0]    p1_next;
    logic signed [P2_W-1:0]    p2_next;
    logic signed [T_W-1:0]     t_next;
    logic signed [P3_W-1:0]    p3_next;
    logic signed [ACC_W-1:0]   acc;
    logic signed [SH_W-1:0]    sh;
    logic signed [Q_WIDTH-1:0] value_next;
    logic [RATE_W-1:0]         one_minus;

    always_comb
    begin
        vld_next  = {vld_reg[2:0], start};
        one_minus = RATE_ONE - req.alpha;

        // stage 1: gamma * max and (1 - alpha) * old
        p1_next = P1_W'($signed({1'b0, req.gamma})) * P1_W'(req.max_q);
        p2_next = P2_W'($signed({1'b0, one_minus})) * P2_W'(req.old_q);

        // stage 2: reward scaled to 2^16 plus discounted max
        t_next = (T_W'(rwd1_reg) <<< REWARD_SHIFT) + T_W'(p1_reg);

        // stage 3: alpha * target
        p3_next = P3_W'($signed({1'b0, alpha2_reg})) * P3_W'(t_reg);

        // stage 4: blend, round half up, saturate
        acc = (ACC_W'(p2c_reg) <<< OLD_SHIFT) + ACC_W'(p3_reg) + ACC_W'(ROUND_HALF);
        sh  = acc[ACC_W-1:ACC_SHIFT];
        if (sh > SH_W'(Q_MAX_V))
            value_next = Q_MAX_V;
        else if (sh < SH_W'(Q_MIN_V))
            value_next = Q_MIN_V;
        else
            value_next = Q_WIDTH'(sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        alpha1_reg <= req.alpha;
        rwd1_reg   <= req.reward;
        t_reg      <= t_next;
        p2b_reg    <= p2_reg;
        alpha2_reg <= alpha1_reg;
        p3_reg     <= p3_next;
        p2c_reg    <= p2b_reg;
        value_reg  <= value_next;
    end

    assign rsp.done  = vld_reg[3];
    assign rsp.value = value_reg;

endmodule

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench of the Q table update engine: directed, random and back-pressure runs
`timescale 1ns / 1ps

module tb_top;
    import qtue_pkg::*;

    localparam int IDLE_SETTLE = 16;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic                       func;
        logic [STATE_W-1:0]         cur;
        logic [STATE_W-1:0]         nxt;
        logic [ACTION_W-1:0]        act;
        logic signed [REWARD_W-1:0] rew;
    } learn_word_t;

    typedef struct {
        logic [COL_W-1:0]          best_action;
        logic signed [Q_WIDTH-1:0] best_q;
        logic signed [Q_WIDTH-1:0] new_q;
    } greedy_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx = CFG_LEARNING_RATE;
    logic [RATE_W-1:0]          cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = FUNC_UPDATE;
    logic [STATE_W-1:0]         cur_state = '0;
    logic [STATE_W-1:0]         next_state_idx = '0;
    logic [ACTION_W-1:0]        action = '0;
    logic signed [REWARD_W-1:0] reward = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [COL_W-1:0]           best_action;
    logic signed [Q_WIDTH-1:0]  best_q;
    logic signed [Q_WIDTH-1:0]  new_q;

    // shadow of the table and rate registers
    logic signed [Q_WIDTH-1:0] q_shadow [DEPTH];
    logic [RATE_W-1:0]         alpha_shadow = LEARN_RATE_RST;
    logic [RATE_W-1:0]         gamma_shadow = DISCOUNT_RST;

    greedy_word_t pending_results[$];

    int errors = 0;
    int cycle_cnt = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int n_updates = 0;
    int n_queries = 0;
    int n_saturated = 0;
    int n_checked = 0;

    q_table_update_engine_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .cur_state      (cur_state),
        .next_state_idx (next_state_idx),
        .action         (action),
        .reward         (reward),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .best_action    (best_action),
        .best_q         (best_q),
        .new_q          (new_q)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: long hold-offs first, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // scan one row: largest value, highest column on ties
    function automatic void scan_row(input int row, output int col, output longint val);
        col = 0;
        val = longint'(q_shadow[row * NUM_ACTIONS]);
        for (int c = 1; c < NUM_ACTIONS; c++)
        begin
            if (longint'(q_shadow[row * NUM_ACTIONS + c]) >= val)
            begin
                val = longint'(q_shadow[row * NUM_ACTIONS + c]);
                col = c;
            end
        end
    endfunction

    // expected output word for one accepted word; updates the shadow table
    function automatic greedy_word_t learn_step(input learn_word_t w);
        greedy_word_t r;
        int row;
        int nrow;
        int col;
        int best_col;
        longint best_val;
        longint a;
        longint g;
        longint old_v;
        longint t;
        longint acc;
        longint nq;
        row = int'(w.cur) % NUM_STATES;
        nrow = int'(w.nxt) % NUM_STATES;
        col = int'(w.act) % NUM_ACTIONS;
        nq = 0;
        if (w.func == FUNC_QUERY)
        begin
            scan_row(row, best_col, best_val);
            n_queries++;
        end
        else
        begin
            a = (alpha_shadow > RATE_ONE) ? longint'(RATE_ONE) : longint'(alpha_shadow);
            g = (gamma_shadow > RATE_ONE) ? longint'(RATE_ONE) : longint'(gamma_shadow);
            old_v = longint'(q_shadow[row * NUM_ACTIONS + col]);
            scan_row(nrow, best_col, best_val);
            t = longint'(w.rew) * 65536 + g * best_val;
            acc = (longint'(RATE_ONE) - a) * old_v * 256 + a * t;
            nq = (acc + ROUND_HALF) >>> ACC_SHIFT;
            if (nq > longint'(Q_MAX_V))
            begin
                nq = longint'(Q_MAX_V);
                n_saturated++;
            end
            else if (nq < longint'(Q_MIN_V))
            begin
                nq = longint'(Q_MIN_V);
                n_saturated++;
            end
            q_shadow[row * NUM_ACTIONS + col] = Q_WIDTH'(nq);
            n_updates++;
        end
        r.best_action = COL_W'(best_col);
        r.best_q = Q_WIDTH'(best_val);
        r.new_q = Q_WIDTH'(nq);
        return r;
    endfunction

    // output checker
    always @(posedge clk)
    begin
        greedy_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word best_action=%0d best_q=%0d new_q=%0d",
                         $time, best_action, best_q, new_q);
                errors++;
            end
            else
            begin
                exp_w = pending_results.pop_front();
                n_checked++;
                if (best_action !== exp_w.best_action)
                begin
                    $display("%0t: best_action expected %0d actual %0d",
                             $time, exp_w.best_action, best_action);
                    errors++;
                end
                if (best_q !== exp_w.best_q)
                begin
                    $display("%0t: best_q expected %0d actual %0d", $time, exp_w.best_q, best_q);
                    errors++;
                end
                if (new_q !== exp_w.new_q)
                begin
                    $display("%0t: new_q expected %0d actual %0d", $time, exp_w.new_q, new_q);
                    errors++;
                end
            end
        end
    end

    // offer one word, wait for acceptance; returns in the step of the accepting edge
    task automatic send_word(input learn_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= w.func;
        cur_state <= w.cur;
        next_state_idx <= w.nxt;
        action <= w.act;
        reward <= w.rew;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(learn_step(w));
    endtask

    task automatic send_fields(input logic f, input int cur, input int nxt, input int act,
                               input int rew);
        learn_word_t w;
        w.func = f;
        w.cur = STATE_W'(cur);
        w.nxt = STATE_W'(nxt);
        w.act = ACTION_W'(act);
        w.rew = REWARD_W'(rew);
        send_word(w);
    endtask

    function automatic learn_word_t random_word(input int update_pct);
        learn_word_t w;
        w.func = ($urandom_range(99) < update_pct) ? FUNC_UPDATE : FUNC_QUERY;
        w.cur = STATE_W'($urandom);
        w.nxt = STATE_W'($urandom);
        w.act = ACTION_W'($urandom);
        case ($urandom_range(7))
            0: w.rew = 8'sd127;
            1: w.rew = -8'sd128;
            default: w.rew = REWARD_W'($urandom);
        endcase
        return w;
    endfunction

    // sender pauses until every result is back and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // both registers in back-to-back cycles; block must be idle
    task automatic set_rates(input int lr, input int disc);
        cfg_wr_en <= 1'b1;
        cfg_idx <= CFG_LEARNING_RATE;
        cfg_data <= RATE_W'(lr);
        @(posedge clk);
        alpha_shadow = RATE_W'(lr);
        cfg_idx <= CFG_DISCOUNT;
        cfg_data <= RATE_W'(disc);
        @(posedge clk);
        gamma_shadow = RATE_W'(disc);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1: begin send_idle_pct = 72; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 72; end
            3: begin send_idle_pct = 13; stall_pct = 13; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
        endcase
    endtask

    // cleared table: every row ties, so the last column wins
    task automatic test_cleared_table();
        set_idling(0);
        send_fields(FUNC_QUERY, 0, 0, 0, 0);
        send_fields(FUNC_QUERY, 7, 7, 3, 0);
    endtask

    task automatic test_default_rates();
        set_idling(0);
        send_fields(FUNC_UPDATE, 0, 1, 0, 127);
        send_fields(FUNC_UPDATE, 7, 7, 3, -128);
        send_fields(FUNC_UPDATE, 3, 0, 1, 1);
        send_fields(FUNC_QUERY, 0, 0, 0, 0);
        send_fields(FUNC_QUERY, 7, 0, 0, 0);
        send_fields(FUNC_QUERY, 3, 0, 0, 0);
    endtask

    task automatic test_rate_extremes();
        wait_idle();
        // rates above one act as one; second update clips high
        set_rates(511, 511);
        send_fields(FUNC_UPDATE, 2, 2, 2, 127);
        send_fields(FUNC_UPDATE, 2, 2, 2, 127);
        send_fields(FUNC_QUERY, 2, 0, 0, 0);
        wait_idle();
        set_rates(256, 256);
        for (int c = 0; c < NUM_ACTIONS; c++)
            send_fields(FUNC_UPDATE, 5, 6, c, -128);
        // row full of minimum values: clips low, then ties on query
        send_fields(FUNC_UPDATE, 5, 5, 1, -128);
        send_fields(FUNC_QUERY, 5, 0, 0, 0);
        wait_idle();
        set_rates(0, 0);
        send_fields(FUNC_UPDATE, 2, 2, 2, 127);
        send_fields(FUNC_QUERY, 2, 0, 0, 0);
        wait_idle();
        set_rates(int'(LEARN_RATE_RST), int'(DISCOUNT_RST));
    endtask

    task automatic test_random_phases();
        int lr;
        int disc;
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            case (ph)
                0: begin lr = int'(LEARN_RATE_RST); disc = int'(DISCOUNT_RST); end
                1: begin lr = 0; disc = 511; end
                2: begin lr = 511; disc = 0; end
                3: begin lr = 256; disc = 256; end
                default: begin lr = $urandom_range(511); disc = $urandom_range(511); end
            endcase
            set_rates(lr, disc);
            set_idling(ph % 4);
            for (int i = 0; i < 80; i++)
                send_word(random_word(65));
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        set_rates($urandom_range(511), $urandom_range(511));
        set_idling(0);
        // receiver holds off long enough for the input side to stall
        hold_left = 150;
        for (int i = 0; i < 12; i++)
            send_word(random_word(50));
        wait_idle();
        hold_left = 60;
        set_idling(3);
        for (int i = 0; i < 12; i++)
            send_word(random_word(80));
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            q_shadow[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cleared_table();
        test_default_rates();
        test_rate_extremes();
        test_random_phases();
        test_backpressure();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);

        $display("covered %0d updates (%0d clipped) and %0d queries, %0d words checked",
                 n_updates, n_saturated, n_queries, n_checked);
        $display("rate settings from zero to above one, four idling mixes, long output hold-offs");
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/qtue_pkg.sv
rtl/qtue_ram.sv
rtl/qtue_calc.sv
rtl/q_table_update_engine_unit.sv
verif/tb_top.sv
